### src/lattice_agreement_node_core_assert.svh
// Assertion macros for the lattice agreement node.
// Used by lattice_agreement_node_core and lagr_proposer; needs no other file.
`ifndef LATTICE_AGREEMENT_NODE_CORE_ASSERT_SVH
`define LATTICE_AGREEMENT_NODE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LAGR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lagr assertion failed");

// next-cycle implication, checked outside reset
`define LAGR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lagr assertion failed");

`endif

### src/lagr_pkg.sv
// Shared types and constants for the lattice agreement node.
// No dependencies; used by lagr_proposer and lattice_agreement_node_core.
`default_nettype none

package lagr_pkg;

	localparam int ID_W    = 8;
	localparam int ROUND_W = 32;
	localparam int SET_W   = 64;
	localparam int CNT_W   = 8;

	// input message kinds
	typedef enum logic [1:0] {
		MODE_PROPOSAL = 2'd0,
		MODE_ACK      = 2'd1,
		MODE_NACK     = 2'd2,
		MODE_PROPOSE  = 2'd3
	} mode_t;

	// output message kinds
	typedef enum logic [1:0] {
		KIND_ACK    = 2'd0,
		KIND_NACK   = 2'd1,
		KIND_BCAST  = 2'd2,
		KIND_DECIDE = 2'd3
	} kind_t;

	// proposer response toward the result register
	typedef struct packed {
		logic                emit;
		kind_t               kind;
		logic [ROUND_W-1:0]  round;
	} prop_rsp_t;

endpackage

`default_nettype wire

### src/lagr_acceptor.sv
// Acceptor side: holds the accepted set and forms ACK/NACK replies.
// Depends on no other file.
`default_nettype none

module lagr_acceptor #(
	parameter int SLOTS = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [SLOTS-1:0] set_in,
	output logic                  reply_ack,
	output logic [SLOTS-1:0]      reply_set
);

	logic [SLOTS-1:0] accepted_q;

	// containing set gives the same union, so the update is always an OR
	assign reply_ack = ((set_in & accepted_q) == accepted_q);
	assign reply_set = accepted_q | set_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_q <= '0;
		end else if (step) begin
			accepted_q <= reply_set;
		end
	end

endmodule

`default_nettype wire

### src/lagr_proposer.sv
// Proposer side: round, tallies, proposed set, retry and decision.
// Depends on lagr_pkg and lattice_agreement_node_core_assert.svh.
`default_nettype none
`include "lattice_agreement_node_core_assert.svh"

module lagr_proposer #(
	parameter int SLOTS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire lagr_pkg::mode_t               mode,
	input  wire logic [lagr_pkg::ROUND_W-1:0]  round_in,
	input  wire logic [SLOTS-1:0]              set_in,
	input  wire logic [lagr_pkg::CNT_W-1:0]    neighbor_count,
	output lagr_pkg::prop_rsp_t                rsp,
	output logic [SLOTS-1:0]                   rsp_set
);

	logic [SLOTS-1:0]              proposed_q;
	logic [lagr_pkg::CNT_W-1:0]    ack_q, nack_q;
	logic [lagr_pkg::ROUND_W-1:0]  round_q;
	logic                          active_q;
	logic                          decided_q;

	logic [SLOTS-1:0]              prop_d;
	logic [lagr_pkg::CNT_W-1:0]    ack_d, nack_d;
	logic [lagr_pkg::ROUND_W-1:0]  round_d;
	logic                          active_d;
	logic                          decided_d;
	logic                          match;
	logic [lagr_pkg::CNT_W-1:0]    ack_t, nack_t;
	logic [lagr_pkg::CNT_W:0]      sum_t;
	logic [lagr_pkg::CNT_W-1:0]    half;
	logic [lagr_pkg::ROUND_W-1:0]  round_inc;

	assign round_inc = round_q + lagr_pkg::ROUND_W'(1);
	assign half      = neighbor_count >> 1;
	assign match     = active_q && (round_in == round_q);

	always_comb begin
		prop_d    = proposed_q;
		ack_d     = ack_q;
		nack_d    = nack_q;
		round_d   = round_q;
		active_d  = active_q;
		decided_d = decided_q;
		ack_t     = ack_q;
		nack_t    = nack_q;
		sum_t     = '0;
		rsp       = '{emit: 1'b0, kind: lagr_pkg::KIND_BCAST, round: round_q};
		rsp_set   = proposed_q;
		unique case (mode) inside
			lagr_pkg::MODE_PROPOSE: begin
				prop_d   = set_in;
				active_d = 1'b1;
				round_d  = round_inc;
				ack_d    = '0;
				nack_d   = '0;
				rsp      = '{emit: 1'b1, kind: lagr_pkg::KIND_BCAST, round: round_inc};
				rsp_set  = set_in;
			end
			lagr_pkg::MODE_ACK, lagr_pkg::MODE_NACK: begin
				// saturating tallies; stale replies leave everything alone
				if (match && mode == lagr_pkg::MODE_ACK && ack_q != '1)
					ack_t = ack_q + lagr_pkg::CNT_W'(1);
				if (match && mode == lagr_pkg::MODE_NACK) begin
					if (nack_q != '1)
						nack_t = nack_q + lagr_pkg::CNT_W'(1);
					prop_d = proposed_q | set_in;
				end
				ack_d   = ack_t;
				nack_d  = nack_t;
				rsp_set = prop_d;
				sum_t   = {1'b0, ack_t} + {1'b0, nack_t};
				if (active_q) begin
					if (nack_t != '0 && sum_t > {1'b0, half}) begin
						// retry wins over decision
						round_d = round_inc;
						ack_d   = '0;
						nack_d  = '0;
						rsp     = '{emit: 1'b1, kind: lagr_pkg::KIND_BCAST,
							round: round_inc};
					end else if (ack_t > half) begin
						active_d  = 1'b0;
						decided_d = 1'b1;
						rsp       = '{emit: 1'b1, kind: lagr_pkg::KIND_DECIDE,
							round: round_q};
					end
				end
			end
			default: begin
				// received proposals belong to the acceptor
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proposed_q <= '0;
			ack_q      <= '0;
			nack_q     <= '0;
			round_q    <= '0;
			active_q   <= 1'b0;
			decided_q  <= 1'b0;
		end else if (step) begin
			proposed_q <= prop_d;
			ack_q      <= ack_d;
			nack_q     <= nack_d;
			round_q    <= round_d;
			active_q   <= active_d;
			decided_q  <= decided_d;
		end
	end

	`LAGR_ASSERT_NEXT(a_decide_sets_flag, clk, arst_n,
		step && rsp.emit && rsp.kind == lagr_pkg::KIND_DECIDE, decided_q && !active_q)
	`LAGR_ASSERT_NEXT(a_retry_clears_tally, clk, arst_n,
		step && rsp.emit && rsp.kind == lagr_pkg::KIND_BCAST, ack_q == '0 && nack_q == '0)
	`LAGR_ASSERT_NEXT(a_propose_activates, clk, arst_n,
		step && mode == lagr_pkg::MODE_PROPOSE, active_q && round_q == $past(round_inc))

endmodule

`default_nettype wire

### src/lattice_agreement_node_core.sv
// Lattice agreement node: one process, value sets as bitmaps.
// Throughput one request per cycle while the result register is not held.
// An input register feeds one pass of acceptor/proposer logic into a result register;
// the slave side stalls only when the input register is full and the result is held.
// Reset (arst_n low, asynchronous): all sets, tallies and round cleared, neighbor_count = 3.
// Requests that make no result (stale or non-settling replies) retire without output.
`default_nettype none
`include "lattice_agreement_node_core_assert.svh"

module lattice_agreement_node_core #(
	parameter int VALUE_SLOTS = 64   // width of the value bitmap, 8..64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// input requests
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	input  wire logic [103:0]  s_axis_tdata,   // sender_id[7:0], round_number[39:8],
	                                           // value_set[103:40]
	input  wire logic [1:0]    s_axis_tuser,   // mode[1:0]
	// results
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	output logic [103:0]       m_axis_tdata,   // out_dest[7:0], out_round[39:8],
	                                           // out_set[103:40]
	output logic [1:0]         m_axis_tuser,   // out_kind[1:0]
	// neighbor_count register
	input  wire logic          cfg_we,
	input  wire logic [7:0]    cfg_wdata
);

	localparam int ID_W    = lagr_pkg::ID_W;
	localparam int ROUND_W = lagr_pkg::ROUND_W;
	localparam int SET_W   = lagr_pkg::SET_W;

	// config
	logic [lagr_pkg::CNT_W-1:0] neighbor_count_q;

	// input register
	logic                    valid_s1;
	lagr_pkg::mode_t         mode_s1;
	logic [ID_W-1:0]         sender_s1;
	logic [ROUND_W-1:0]      round_s1;
	logic [VALUE_SLOTS-1:0]  set_s1;

	// result register
	logic                    out_valid_q;
	lagr_pkg::kind_t         out_kind_q;
	logic [ID_W-1:0]         out_dest_q;
	logic [ROUND_W-1:0]      out_round_q;
	logic [VALUE_SLOTS-1:0]  out_set_q;

	logic                    advance;
	logic                    in_fire;
	logic                    acc_step, prop_step;
	logic                    reply_ack;
	logic [VALUE_SLOTS-1:0]  reply_set;
	lagr_pkg::prop_rsp_t     prop_rsp;
	logic [VALUE_SLOTS-1:0]  prop_set;

	logic                    res_emit;
	lagr_pkg::kind_t         res_kind;
	logic [ID_W-1:0]         res_dest;
	logic [ROUND_W-1:0]      res_round;
	logic [VALUE_SLOTS-1:0]  res_set;

	// the held request moves on whenever the result slot is free or draining
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	assign acc_step  = advance && (mode_s1 == lagr_pkg::MODE_PROPOSAL);
	assign prop_step = advance && (mode_s1 != lagr_pkg::MODE_PROPOSAL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neighbor_count_q <= 8'd3;
		end else if (cfg_we) begin
			neighbor_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// payload, no reset; bits above VALUE_SLOTS dropped here
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_s1   <= lagr_pkg::mode_t'(s_axis_tuser);
			sender_s1 <= s_axis_tdata[7:0];
			round_s1  <= s_axis_tdata[39:8];
			set_s1    <= s_axis_tdata[40 +: VALUE_SLOTS];
		end
	end

	lagr_acceptor #(
		.SLOTS     (VALUE_SLOTS)
	) u_acceptor (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (acc_step),
		.set_in    (set_s1),
		.reply_ack (reply_ack),
		.reply_set (reply_set)
	);

	lagr_proposer #(
		.SLOTS          (VALUE_SLOTS)
	) u_proposer (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (prop_step),
		.mode           (mode_s1),
		.round_in       (round_s1),
		.set_in         (set_s1),
		.neighbor_count (neighbor_count_q),
		.rsp            (prop_rsp),
		.rsp_set        (prop_set)
	);

	// result select: acceptor replies echo the sender and round
	always_comb begin
		unique case (mode_s1)
			lagr_pkg::MODE_PROPOSAL: begin
				res_emit  = 1'b1;
				res_kind  = reply_ack ? lagr_pkg::KIND_ACK : lagr_pkg::KIND_NACK;
				res_dest  = sender_s1;
				res_round = round_s1;
				res_set   = reply_set;
			end
			default: begin
				res_emit  = prop_rsp.emit;
				res_kind  = prop_rsp.kind;
				res_dest  = '0;
				res_round = prop_rsp.round;
				res_set   = prop_set;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_emit;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_emit) begin
			out_kind_q  <= res_kind;
			out_dest_q  <= res_dest;
			out_round_q <= res_round;
			out_set_q   <= res_set;
		end
	end

	assign m_axis_tvalid         = out_valid_q;
	assign m_axis_tuser          = out_kind_q;
	assign m_axis_tdata[7:0]     = out_dest_q;
	assign m_axis_tdata[39:8]    = out_round_q;
	assign m_axis_tdata[103:40]  = SET_W'(out_set_q);

	`LAGR_ASSERT_NOW(a_ready_when_slot_free, clk, arst_n, !out_valid_q, s_axis_tready)
	`LAGR_ASSERT_NEXT(a_reply_always_out, clk, arst_n, acc_step, out_valid_q)
	`LAGR_ASSERT_NEXT(a_result_held, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

`default_nettype wire
